// File: rtl/core/hsp_pkg.sv
`timescale 1ns / 1ps

package hsp_pkg;

    // coefficient width after sign extension and negation (-2^31 negates to +2^31)
    localparam int COEF_W    = 33;
    localparam int REG_W     = 32;
    localparam int FRAC_BITS = 40;
    localparam int ADDR_W    = 5;
    localparam int PIPE_LAT  = 4;

    typedef enum logic [2:0] {
        REG_SHIFT_X   = 3'd0,
        REG_SHIFT_Y   = 3'd1,
        REG_SHIFT_Z   = 3'd2,
        REG_SCALE_ADJ = 3'd3,
        REG_ROT_X     = 3'd4,
        REG_ROT_Y     = 3'd5,
        REG_ROT_Z     = 3'd6,
        REG_REVERSE   = 3'd7
    } hsp_reg_idx_t;

    localparam logic [REG_W-1:0] RST_SHIFT_X   = -32'sd29258416;
    localparam logic [REG_W-1:0] RST_SHIFT_Y   = 32'sd8202289;
    localparam logic [REG_W-1:0] RST_SHIFT_Z   = -32'sd35524444;
    localparam logic [REG_W-1:0] RST_SCALE_ADJ = 32'sd22528330;
    localparam logic [REG_W-1:0] RST_ROT_X     = -32'sd800653;
    localparam logic [REG_W-1:0] RST_ROT_Y     = -32'sd1316649;
    localparam logic [REG_W-1:0] RST_ROT_Z     = -32'sd4488884;

    // effective parameter set as seen by the row datapaths
    typedef struct packed {
        logic signed [COEF_W-1:0] s;
        logic signed [COEF_W-1:0] rx;
        logic signed [COEF_W-1:0] ry;
        logic signed [COEF_W-1:0] rz;
        logic signed [COEF_W-1:0] nrx;
        logic signed [COEF_W-1:0] nry;
        logic signed [COEF_W-1:0] nrz;
        logic signed [COEF_W-1:0] dx;
        logic signed [COEF_W-1:0] dy;
        logic signed [COEF_W-1:0] dz;
    } hsp_coef_t;

    function automatic logic signed [COEF_W-1:0] coef_eff(
        input logic [REG_W-1:0] value,
        input logic             neg
    );
        logic signed [COEF_W-1:0] ext;
        ext = COEF_W'($signed(value));
        return neg ? -ext : ext;
    endfunction

endpackage

// File: rtl/core/hsp_regs.sv
`timescale 1ns / 1ps

module hsp_regs
    import hsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready,
    output hsp_coef_t         coef
);

    logic [REG_W-1:0] shift_x_reg;
    logic [REG_W-1:0] shift_y_reg;
    logic [REG_W-1:0] shift_z_reg;
    logic [REG_W-1:0] scale_adj_reg;
    logic [REG_W-1:0] rot_x_reg;
    logic [REG_W-1:0] rot_y_reg;
    logic [REG_W-1:0] rot_z_reg;
    logic             reverse_reg;
    logic             wr_en;
    hsp_reg_idx_t     idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = hsp_reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_x_reg   <= RST_SHIFT_X;
            shift_y_reg   <= RST_SHIFT_Y;
            shift_z_reg   <= RST_SHIFT_Z;
            scale_adj_reg <= RST_SCALE_ADJ;
            rot_x_reg     <= RST_ROT_X;
            rot_y_reg     <= RST_ROT_Y;
            rot_z_reg     <= RST_ROT_Z;
            reverse_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SHIFT_X:   shift_x_reg   <= pwdata;
                REG_SHIFT_Y:   shift_y_reg   <= pwdata;
                REG_SHIFT_Z:   shift_z_reg   <= pwdata;
                REG_SCALE_ADJ: scale_adj_reg <= pwdata;
                REG_ROT_X:     rot_x_reg     <= pwdata;
                REG_ROT_Y:     rot_y_reg     <= pwdata;
                REG_ROT_Z:     rot_z_reg     <= pwdata;
                REG_REVERSE:   reverse_reg   <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SHIFT_X:   prdata = shift_x_reg;
            REG_SHIFT_Y:   prdata = shift_y_reg;
            REG_SHIFT_Z:   prdata = shift_z_reg;
            REG_SCALE_ADJ: prdata = scale_adj_reg;
            REG_ROT_X:     prdata = rot_x_reg;
            REG_ROT_Y:     prdata = rot_y_reg;
            REG_ROT_Z:     prdata = rot_z_reg;
            REG_REVERSE:   prdata = {{(REG_W-1){1'b0}}, reverse_reg};
            default:       prdata = '0;
        endcase
    end

    // reverse flips the sign of every parameter; the negated rotations feed
    // the antisymmetric terms of the rotation matrix
    always_comb
    begin
        coef.s   = coef_eff(scale_adj_reg, reverse_reg);
        coef.rx  = coef_eff(rot_x_reg, reverse_reg);
        coef.ry  = coef_eff(rot_y_reg, reverse_reg);
        coef.rz  = coef_eff(rot_z_reg, reverse_reg);
        coef.nrx = coef_eff(rot_x_reg, ~reverse_reg);
        coef.nry = coef_eff(rot_y_reg, ~reverse_reg);
        coef.nrz = coef_eff(rot_z_reg, ~reverse_reg);
        coef.dx  = coef_eff(shift_x_reg, reverse_reg);
        coef.dy  = coef_eff(shift_y_reg, reverse_reg);
        coef.dz  = coef_eff(shift_z_reg, reverse_reg);
    end

endmodule

// File: rtl/core/hsp_row.sv
`timescale 1ns / 1ps

module hsp_row
    import hsp_pkg::*;
#(
    parameter int COORD_WIDTH = 40
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] self_val,
    input  logic signed [COORD_WIDTH-1:0] op [3],
    input  logic signed [COEF_W-1:0]      cf [3],
    input  logic signed [COEF_W-1:0]      shift,
    output logic                          out_valid,
    output logic signed [COORD_WIDTH-1:0] out_val,
    output logic                          out_clip
);

    localparam int LO_W   = COORD_WIDTH / 2;
    localparam int HI_W   = COORD_WIDTH - LO_W;
    localparam int PL_W   = LO_W + 1 + COEF_W;
    localparam int PH_W   = HI_W + COEF_W;
    localparam int PROD_W = COORD_WIDTH + COEF_W;
    localparam int BASE_W = ((COORD_WIDTH > COEF_W) ? COORD_WIDTH : COEF_W) + 1;
    localparam int ACC_W  = COORD_WIDTH + 43;
    localparam int RND_W  = ACC_W - FRAC_BITS;

    localparam logic signed [ACC_W-1:0]       HALF   = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // stage 1: split partial products
    logic signed [PL_W-1:0]        pl_reg [3];
    logic signed [PH_W-1:0]        ph_reg [3];
    logic signed [BASE_W-1:0]      base1_reg;
    logic                          v1_reg;
    // stage 2: row sum
    logic signed [ACC_W-1:0]       sum_reg;
    logic signed [BASE_W-1:0]      base2_reg;
    logic                          v2_reg;
    // stage 3: rounded
    logic signed [RND_W-1:0]       rnd_reg;
    logic                          v3_reg;
    // stage 4: saturated output
    logic signed [COORD_WIDTH-1:0] out_reg;
    logic                          clip_reg;
    logic                          v4_reg;

    logic signed [PL_W-1:0]        pl_next [3];
    logic signed [PH_W-1:0]        ph_next [3];
    logic signed [BASE_W-1:0]      base1_next;
    logic signed [PROD_W-1:0]      prod [3];
    logic signed [ACC_W-1:0]       sum_next;
    logic signed [ACC_W-1:0]       acc;
    logic signed [RND_W-1:0]       rnd_next;
    logic [RND_W-COORD_WIDTH:0]    top_bits;
    logic                          fits;
    logic signed [COORD_WIDTH-1:0] out_next;
    logic                          clip_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pl_next[k] = PL_W'($signed({1'b0, op[k][LO_W-1:0]})) * PL_W'(cf[k]);
            ph_next[k] = PH_W'($signed(op[k][COORD_WIDTH-1:LO_W])) * PH_W'(cf[k]);
        end
        base1_next = BASE_W'(self_val) + BASE_W'(shift);
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod[k] = (PROD_W'(ph_reg[k]) <<< LO_W) + PROD_W'(pl_reg[k]);
        end
        sum_next = ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'(prod[2]);
    end

    // round half up at 2^-40 of the correction, then drop the fraction
    always_comb
    begin
        acc      = sum_reg + (ACC_W'(base2_reg) <<< FRAC_BITS) + HALF;
        rnd_next = $signed(acc[ACC_W-1:FRAC_BITS]);
    end

    always_comb
    begin
        top_bits  = rnd_reg[RND_W-1:COORD_WIDTH-1];
        fits      = (&top_bits) | ~(|top_bits);
        clip_next = v3_reg & ~fits;
        if (fits)
        begin
            out_next = rnd_reg[COORD_WIDTH-1:0];
        end
        else if (rnd_reg[RND_W-1])
        begin
            out_next = SAT_MIN;
        end
        else
        begin
            out_next = SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        pl_reg    <= pl_next;
        ph_reg    <= ph_next;
        base1_reg <= base1_next;
        sum_reg   <= sum_next;
        base2_reg <= base1_reg;
        rnd_reg   <= rnd_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            clip_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            clip_reg <= clip_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_val   = out_reg;
    assign out_clip  = clip_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##PIPE_LAT out_valid)
        else $error("row result did not arrive after pipeline latency");

    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_clip |-> (out_val == SAT_MAX || out_val == SAT_MIN))
        else $error("clipped row value is not a saturation bound");

    a_clip_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_clip |-> out_valid)
        else $error("clip flag raised without a result");

endmodule

// File: rtl/core/helmert_seven_param_transform_core.sv
`timescale 1ns / 1ps
// Small-angle seven-parameter Helmert transform, one point per request.
// Request channel: drive in_x/in_y/in_z and pulse start; a request is taken
// at each rising edge with start high and busy low. busy is always low, so
// a new point may be issued every cycle.
// Result channel: out_x/out_y/out_z/clipped are shown for one cycle with done
// high, once the request has passed every row pipeline stage. There is no
// back-pressure: the receiver must take each result in the cycle it appears.
// Pipeline: partial products of each coordinate half by 33-bit coefficients,
// row sum, translation and rounding, saturation into the output register.
// Throughput is one point per clock, set by the three row pipelines.
// Configuration: APB registers at byte addresses 0..28 (shifts, scale,
// rotations, reverse). Write them only while no request is in flight.
// Reset: registers return to their default datum parameters, all pipeline
// valid bits clear, no result is shown.
module helmert_seven_param_transform_core
    import hsp_pkg::*;
#(
    parameter int COORD_WIDTH = 40
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [REG_W-1:0]              pwdata,
    output logic [REG_W-1:0]              prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic signed [COORD_WIDTH-1:0] in_z,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output logic                          clipped
);

    hsp_coef_t                     coef;
    logic                          req;
    logic signed [COORD_WIDTH-1:0] ops [3];
    logic signed [COEF_W-1:0]      cf_x [3];
    logic signed [COEF_W-1:0]      cf_y [3];
    logic signed [COEF_W-1:0]      cf_z [3];
    logic                          vx;
    logic                          vy;
    logic                          vz;
    logic                          clip_x;
    logic                          clip_y;
    logic                          clip_z;

    assign busy = 1'b0;
    assign req  = start & ~busy;

    assign ops[0] = in_x;
    assign ops[1] = in_y;
    assign ops[2] = in_z;

    assign cf_x[0] = coef.s;
    assign cf_x[1] = coef.nrz;
    assign cf_x[2] = coef.ry;
    assign cf_y[0] = coef.rz;
    assign cf_y[1] = coef.s;
    assign cf_y[2] = coef.nrx;
    assign cf_z[0] = coef.nry;
    assign cf_z[1] = coef.rx;
    assign cf_z[2] = coef.s;

    hsp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    hsp_row #(.COORD_WIDTH(COORD_WIDTH)) u_row_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req),
        .self_val  (in_x),
        .op        (ops),
        .cf        (cf_x),
        .shift     (coef.dx),
        .out_valid (vx),
        .out_val   (out_x),
        .out_clip  (clip_x)
    );

    hsp_row #(.COORD_WIDTH(COORD_WIDTH)) u_row_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req),
        .self_val  (in_y),
        .op        (ops),
        .cf        (cf_y),
        .shift     (coef.dy),
        .out_valid (vy),
        .out_val   (out_y),
        .out_clip  (clip_y)
    );

    hsp_row #(.COORD_WIDTH(COORD_WIDTH)) u_row_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req),
        .self_val  (in_z),
        .op        (ops),
        .cf        (cf_z),
        .shift     (coef.dz),
        .out_valid (vz),
        .out_val   (out_z),
        .out_clip  (clip_z)
    );

    assign done    = vx & vy & vz;
    assign clipped = clip_x | clip_y | clip_z;

endmodule

// File: sim/helmert_point_checker.sv
`timescale 1ns / 1ps

module helmert_point_checker
    import hsp_pkg::*;
#(
    parameter int COORD_WIDTH = 40
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [REG_W-1:0]              pwdata,
    input  logic                          start,
    input  logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic signed [COORD_WIDTH-1:0] in_z,
    input  logic                          done,
    input  logic signed [COORD_WIDTH-1:0] out_x,
    input  logic signed [COORD_WIDTH-1:0] out_y,
    input  logic signed [COORD_WIDTH-1:0] out_z,
    input  logic                          clipped,
    output int                            mismatches,
    output int                            outstanding
);

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
        logic signed [COORD_WIDTH-1:0] pz;
        logic                          clip;
    } helmert_point_t;

    logic [REG_W-1:0] datum_reg [8];
    helmert_point_t   pending_transforms [$];
    helmert_point_t   want;
    int               step_errs;

    function automatic wide_t eff_param(input logic [REG_W-1:0] value, input logic neg);
        logic signed [REG_W-1:0] sv;
        wide_t                   w;
        sv = value;
        w  = sv;
        return neg ? -w : w;
    endfunction

    // one output coordinate: {clip, value}
    function automatic logic [COORD_WIDTH:0] helmert_row(
        input wide_t axis_in,
        input wide_t a,
        input wide_t ca,
        input wide_t b,
        input wide_t cb,
        input wide_t c,
        input wide_t cc,
        input wide_t shift
    );
        wide_t acc;
        wide_t hi_lim;
        wide_t lo_lim;
        hi_lim = (wide_t'(1) <<< (COORD_WIDTH - 1)) - wide_t'(1);
        lo_lim = -(wide_t'(1) <<< (COORD_WIDTH - 1));
        // exact sum at 2^-56 m, round half up, floor back to 2^-16 m
        acc = a * ca + b * cb + c * cc + ((axis_in + shift) <<< FRAC_BITS)
            + (wide_t'(1) <<< (FRAC_BITS - 1));
        acc = acc >>> FRAC_BITS;
        if (acc > hi_lim)
            return {1'b1, hi_lim[COORD_WIDTH-1:0]};
        if (acc < lo_lim)
            return {1'b1, lo_lim[COORD_WIDTH-1:0]};
        return {1'b0, acc[COORD_WIDTH-1:0]};
    endfunction

    function automatic helmert_point_t helmert_predict(
        input logic signed [COORD_WIDTH-1:0] x,
        input logic signed [COORD_WIDTH-1:0] y,
        input logic signed [COORD_WIDTH-1:0] z
    );
        wide_t                wx;
        wide_t                wy;
        wide_t                wz;
        wide_t                s;
        wide_t                rx;
        wide_t                ry;
        wide_t                rz;
        wide_t                dx;
        wide_t                dy;
        wide_t                dz;
        logic                 neg;
        logic [COORD_WIDTH:0] row_x;
        logic [COORD_WIDTH:0] row_y;
        logic [COORD_WIDTH:0] row_z;
        helmert_point_t       p;
        neg = datum_reg[REG_REVERSE][0];
        wx  = x;
        wy  = y;
        wz  = z;
        dx  = eff_param(datum_reg[REG_SHIFT_X], neg);
        dy  = eff_param(datum_reg[REG_SHIFT_Y], neg);
        dz  = eff_param(datum_reg[REG_SHIFT_Z], neg);
        s   = eff_param(datum_reg[REG_SCALE_ADJ], neg);
        rx  = eff_param(datum_reg[REG_ROT_X], neg);
        ry  = eff_param(datum_reg[REG_ROT_Y], neg);
        rz  = eff_param(datum_reg[REG_ROT_Z], neg);
        row_x = helmert_row(wx, wx, s, wy, -rz, wz, ry, dx);
        row_y = helmert_row(wy, wx, rz, wy, s, wz, -rx, dy);
        row_z = helmert_row(wz, wx, -ry, wy, rx, wz, s, dz);
        p.px   = row_x[COORD_WIDTH-1:0];
        p.py   = row_y[COORD_WIDTH-1:0];
        p.pz   = row_z[COORD_WIDTH-1:0];
        p.clip = row_x[COORD_WIDTH] | row_y[COORD_WIDTH] | row_z[COORD_WIDTH];
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            datum_reg[REG_SHIFT_X]   <= RST_SHIFT_X;
            datum_reg[REG_SHIFT_Y]   <= RST_SHIFT_Y;
            datum_reg[REG_SHIFT_Z]   <= RST_SHIFT_Z;
            datum_reg[REG_SCALE_ADJ] <= RST_SCALE_ADJ;
            datum_reg[REG_ROT_X]     <= RST_ROT_X;
            datum_reg[REG_ROT_Y]     <= RST_ROT_Y;
            datum_reg[REG_ROT_Z]     <= RST_ROT_Z;
            datum_reg[REG_REVERSE]   <= '0;
            pending_transforms.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            step_errs = 0;
            if (psel && penable && pwrite && pready)
            begin
                if (hsp_reg_idx_t'(paddr[ADDR_W-1:2]) == REG_REVERSE)
                    datum_reg[REG_REVERSE] <= REG_W'(pwdata[0]);
                else
                    datum_reg[paddr[ADDR_W-1:2]] <= pwdata;
            end
            if (start && !busy)
                pending_transforms.push_back(helmert_predict(in_x, in_y, in_z));
            if (done)
            begin
                if (pending_transforms.size() == 0)
                begin
                    $display("%0t: result with no request pending: x %0d y %0d z %0d clipped %0b",
                             $time, out_x, out_y, out_z, clipped);
                    step_errs = step_errs + 1;
                end
                else
                begin
                    want = pending_transforms.pop_front();
                    if (out_x !== want.px)
                    begin
                        $display("%0t: out_x expected %0d, got %0d", $time, want.px, out_x);
                        step_errs = step_errs + 1;
                    end
                    if (out_y !== want.py)
                    begin
                        $display("%0t: out_y expected %0d, got %0d", $time, want.py, out_y);
                        step_errs = step_errs + 1;
                    end
                    if (out_z !== want.pz)
                    begin
                        $display("%0t: out_z expected %0d, got %0d", $time, want.pz, out_z);
                        step_errs = step_errs + 1;
                    end
                    if (clipped !== want.clip)
                    begin
                        $display("%0t: clipped expected %0b, got %0b", $time, want.clip, clipped);
                        step_errs = step_errs + 1;
                    end
                end
            end
            mismatches  <= mismatches + step_errs;
            outstanding <= pending_transforms.size();
        end
    end

endmodule

// File: sim/tb_helmert_seven_param_transform_core.sv
`timescale 1ns / 1ps

module tb_helmert_seven_param_transform_core;
    import hsp_pkg::*;

    localparam int CW = 40;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [REG_W-1:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [REG_W-1:0] PMIN = 32'h8000_0000;

    typedef struct {
        logic [REG_W-1:0] shift_x;
        logic [REG_W-1:0] shift_y;
        logic [REG_W-1:0] shift_z;
        logic [REG_W-1:0] scale;
        logic [REG_W-1:0] rot_x;
        logic [REG_W-1:0] rot_y;
        logic [REG_W-1:0] rot_z;
        logic             reverse;
    } datum_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [REG_W-1:0]     pwdata;
    logic [REG_W-1:0]     prdata;
    logic                 pready;
    logic                 start;
    logic                 busy;
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
    logic                 done;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 clipped;
    int                   mismatches;
    int                   outstanding;
    bit                   no_gaps;

    helmert_seven_param_transform_core #(.COORD_WIDTH(CW)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .in_x    (in_x),
        .in_y    (in_y),
        .in_z    (in_z),
        .done    (done),
        .out_x   (out_x),
        .out_y   (out_y),
        .out_z   (out_z),
        .clipped (clipped)
    );

    helmert_point_checker #(.COORD_WIDTH(CW)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .start       (start),
        .busy        (busy),
        .in_x        (in_x),
        .in_y        (in_y),
        .in_z        (in_z),
        .done        (done),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .clipped     (clipped),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic apb_write(input hsp_reg_idx_t idx, input logic [REG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // stop requests and let the pipeline drain
    task automatic drain_points();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic load_datum(input datum_t d);
        drain_points();
        apb_write(REG_SHIFT_X, d.shift_x);
        apb_write(REG_SHIFT_Y, d.shift_y);
        apb_write(REG_SHIFT_Z, d.shift_z);
        apb_write(REG_SCALE_ADJ, d.scale);
        apb_write(REG_ROT_X, d.rot_x);
        apb_write(REG_ROT_Y, d.rot_y);
        apb_write(REG_ROT_Z, d.rot_z);
        apb_write(REG_REVERSE, {31'($urandom_range(0, 'h7FFF_FFFF)), d.reverse});
    endtask

    task automatic send_point(
        input logic signed [CW-1:0] x,
        input logic signed [CW-1:0] y,
        input logic signed [CW-1:0] z
    );
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        in_x  <= x;
        in_y  <= y;
        in_z  <= z;
        do @(posedge clk); while (busy);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        logic signed [CW-1:0] v;
        v = CW'({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 1) ? CMAX : CMIN;
            1, 2, 3: ;
            default: v = v >>> $urandom_range(1, 24);
        endcase
        return v;
    endfunction

    function automatic logic [REG_W-1:0] rand_param();
        logic signed [REG_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0:       v = $urandom_range(0, 1) ? PMAX : PMIN;
            1, 2:    ;
            default: v = v >>> $urandom_range(4, 24);
        endcase
        return v;
    endfunction

    task automatic run_directed();
        send_point('0, '0, '0);
        send_point(CMAX, CMAX, CMAX);
        send_point(CMIN, CMIN, CMIN);
        send_point(CMAX, '0, '0);
        send_point('0, CMAX, '0);
        send_point('0, '0, CMAX);
        send_point(CMIN, CMAX, CMIN);
        send_point(CMAX, CMIN, CMAX);
        send_point(40'sd1, -40'sd1, 40'sd1);
        send_point(-40'sd1, 40'sd1, -40'sd1);
        // typical mid-latitude earth-centred point
        send_point(40'sd260833280000, -40'sd655360000, 40'sd325713920000);
        send_point(CMAX, CMIN, '0);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 32 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send_point(rand_coord(), rand_coord(), rand_coord());
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        datum_t d;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        start   <= 1'b0;
        in_x    <= '0;
        in_y    <= '0;
        in_z    <= '0;
        no_gaps = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-up datum
        run_directed();

        d = '{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 1'b0};
        load_datum(d);
        run_directed();

        // most negative parameters, negated at full precision
        d = '{PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, 1'b1};
        load_datum(d);
        run_random(60);

        d.reverse = 1'b0;
        load_datum(d);
        run_random(60);

        d = '{'0, '0, '0, '0, '0, '0, '0, 1'b0};
        load_datum(d);
        run_random(60);

        // inverse of the power-up datum
        d = '{RST_SHIFT_X, RST_SHIFT_Y, RST_SHIFT_Z, RST_SCALE_ADJ,
              RST_ROT_X, RST_ROT_Y, RST_ROT_Z, 1'b1};
        load_datum(d);
        run_random(100);

        for (int k = 0; k < 6; k++)
        begin
            d = '{rand_param(), rand_param(), rand_param(), rand_param(),
                  rand_param(), rand_param(), rand_param(), 1'($urandom_range(0, 1))};
            load_datum(d);
            run_random(100);
        end

        drain_points();
        repeat (PIPE_LAT + 2) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/hsp_pkg.sv
rtl/core/hsp_regs.sv
rtl/core/hsp_row.sv
rtl/core/helmert_seven_param_transform_core.sv
sim/helmert_point_checker.sv
sim/tb_helmert_seven_param_transform_core.sv
